FILE: src/bba_pkg.sv
// Package for the buddy block allocator: sizes, flag bits, status codes
// and the heap index helper. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bba_pkg;
    localparam int TOTAL_SIZE = 2048;
    localparam int MIN_BLOCK  = 8;
    localparam int LG_TOTAL   = $clog2(TOTAL_SIZE);
    localparam int LG_MIN     = $clog2(MIN_BLOCK);
    localparam int MAX_LVL    = LG_TOTAL - LG_MIN;
    localparam int NODE_COUNT = 2 * (TOTAL_SIZE / MIN_BLOCK) - 1;
    localparam int LVL_W      = $clog2(MAX_LVL + 1);
    localparam int POS_W      = (MAX_LVL > 0) ? MAX_LVL : 1;
    localparam int IDX_W      = $clog2(NODE_COUNT);
    localparam int REQ_W      = 12;
    localparam int OFF_W      = 11;
    localparam int SIZE_W     = 12;
    localparam int ST_W       = 2;

    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_NOSPACE = 2'd1;
    localparam logic [ST_W-1:0] ST_NOBLOCK = 2'd2;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // Bit 0 marks an allocated leaf, bit 1 a split node.
    typedef logic [1:0] t_flags;
    localparam t_flags FLAGS_FREE  = 2'b00;
    localparam t_flags FLAGS_ALLOC = 2'b01;
    localparam t_flags FLAGS_SPLIT = 2'b10;

    typedef struct packed {
        logic             fail;
        logic [LVL_W-1:0] lvl;
    } t_need;

    function automatic logic [IDX_W-1:0] node_idx(input logic [LVL_W-1:0] lvl,
                                                  input logic [POS_W-1:0] pos);
        return (IDX_W'(1) << lvl) - IDX_W'(1) + IDX_W'(pos);
    endfunction
endpackage
`default_nettype wire

FILE: src/bba_if.sv
// Handshake interfaces for the request and response channels.
// Depends on bba_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface bba_req_if import bba_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             kind;
    logic [REQ_W-1:0] request_size;
    logic [OFF_W-1:0] block_offset;
    modport source (output valid, kind, request_size, block_offset, input ready);
    modport sink   (input valid, kind, request_size, block_offset, output ready);
endinterface

interface bba_rsp_if import bba_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ST_W-1:0]   status;
    logic [OFF_W-1:0]  granted_offset;
    logic [SIZE_W-1:0] granted_size;
    modport source (output valid, status, granted_offset, granted_size, input ready);
    modport sink   (input valid, status, granted_offset, granted_size, output ready);
endinterface
`default_nettype wire

FILE: src/bba_size_dec.sv
// Rounds a requested size to the tree level of the block that serves it.
// Depends on bba_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bba_size_dec import bba_pkg::*; (
    input  wire logic [REQ_W-1:0] i_size,
    output t_need                 o_need
);
    always_comb begin
        o_need.lvl  = '0;
        o_need.fail = ({1'b0, i_size} > (REQ_W+1)'(TOTAL_SIZE));
        // Deepest level whose block still covers the request wins.
        for (int d = 0; d <= MAX_LVL; d++) begin
            if ((REQ_W+1)'(TOTAL_SIZE >> d) >= {1'b0, i_size}) begin
                o_need.lvl = LVL_W'(d);
            end
        end
    end
endmodule
`default_nettype wire

FILE: src/buddy_block_allocator.sv
// Buddy block allocator top level: node flag memory and the walk sequencer.
// Depends on bba_pkg, bba_if and bba_size_dec.
//
//  channel  | dir | word
//  i_req    | in  | kind, request_size, block_offset
//  o_rsp    | out | status, granted_offset, granted_size
//
// Each visited tree node is read, then evaluated, on the single port of the
// flag memory; each split level adds the states SPL and SPR, and each merge
// level the states FRW, MRD and MEV. An allocate search can visit every node
// when the pool is split down to minimum blocks. A free walks down to its
// block, then merges upward one level at a time while the buddy is free.
// Reset clears only the root flags; deeper nodes are written before use.
// A new request is taken while the previous response still waits.
`timescale 1ns / 1ps
`default_nettype none
module buddy_block_allocator import bba_pkg::*; (
    input wire logic i_clk,
    input wire logic i_rst_n,
    bba_req_if.sink   i_req,
    bba_rsp_if.source o_rsp
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD   = 4'd1;
    localparam logic [3:0] S_EV   = 4'd2;
    localparam logic [3:0] S_SPL  = 4'd3;
    localparam logic [3:0] S_SPR  = 4'd4;
    localparam logic [3:0] S_ALC  = 4'd5;
    localparam logic [3:0] S_FRW  = 4'd6;
    localparam logic [3:0] S_MRD  = 4'd7;
    localparam logic [3:0] S_MEV  = 4'd8;
    localparam logic [3:0] S_FIN  = 4'd9;

    logic [3:0]        r_state, n_state;
    logic              r_kind;
    logic [OFF_W-1:0]  r_at;
    t_need             r_need;
    logic [LVL_W-1:0]  r_lvl, n_lvl;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [LVL_W-1:0]  r_res_lvl, n_res_lvl;
    logic [OFF_W-1:0]  r_res_off, n_res_off;
    logic [ST_W-1:0]   r_res_st, n_res_st;
    t_flags            r_root, n_root;
    t_flags            r_rdata;
    logic              r_o_valid;
    logic [ST_W-1:0]   r_o_status;
    logic [OFF_W-1:0]  r_o_off;
    logic [SIZE_W-1:0] r_o_size;

    t_flags            mem [NODE_COUNT];
    logic              mem_we;
    logic [IDX_W-1:0]  mem_addr;
    t_flags            mem_wd;

    t_need             dec_need;
    t_flags            cur;
    logic [IDX_W-1:0]  cur_idx;
    logic [POS_W:0]    nxt_q;
    logic [LVL_W-1:0]  nxt_tz;
    logic [OFF_W-1:0]  cur_off;
    logic              at_bit;
    logic              out_load;

    bba_size_dec u_dec (
        .i_size (i_req.request_size),
        .o_need (dec_need)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign cur_idx     = node_idx(r_lvl, r_pos);
    assign cur         = (r_lvl == '0) ? r_root : r_rdata;
    assign cur_off     = OFF_W'(r_pos) << (LVL_W'(LG_TOTAL) - r_lvl);
    assign at_bit      = r_at[LG_TOTAL - 1 - 32'(r_lvl)];
    assign out_load    = (r_state == S_FIN) && (!r_o_valid || o_rsp.ready);

    // Next preorder node after a skipped subtree: climb out of right children.
    always_comb begin
        nxt_q  = (POS_W+1)'(r_pos) + (POS_W+1)'(1);
        nxt_tz = '0;
        for (int i = POS_W - 1; i >= 0; i--) begin
            if (nxt_q[i]) begin
                nxt_tz = LVL_W'(i);
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        n_lvl     = r_lvl;
        n_pos     = r_pos;
        n_res_lvl = r_res_lvl;
        n_res_off = r_res_off;
        n_res_st  = r_res_st;
        n_root    = r_root;
        mem_we    = 1'b0;
        mem_addr  = cur_idx;
        mem_wd    = FLAGS_FREE;
        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_lvl = '0;
                    n_pos = '0;
                    if (i_req.kind == KIND_ALLOC && dec_need.fail) begin
                        n_res_st = ST_NOSPACE;
                        n_state  = S_FIN;
                    end else if (i_req.kind == KIND_FREE &&
                                 {1'b0, i_req.block_offset} >= (OFF_W+1)'(TOTAL_SIZE)) begin
                        n_res_st = ST_NOBLOCK;
                        n_state  = S_FIN;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                n_state = S_EV;
            end
            S_EV: begin
                if (r_kind == KIND_ALLOC) begin
                    if (cur[0] || r_lvl > r_need.lvl || (cur[1] && r_lvl == r_need.lvl)) begin
                        if (nxt_q == ((POS_W+1)'(1) << r_lvl)) begin
                            n_res_st = ST_NOSPACE;
                            n_state  = S_FIN;
                        end else begin
                            n_pos   = POS_W'(nxt_q >> nxt_tz);
                            n_lvl   = r_lvl - nxt_tz;
                            n_state = S_RD;
                        end
                    end else if (!cur[1]) begin
                        n_res_off = cur_off;
                        n_state   = (r_lvl < r_need.lvl) ? S_SPL : S_ALC;
                    end else begin
                        n_lvl   = r_lvl + LVL_W'(1);
                        n_pos   = POS_W'({r_pos, 1'b0});
                        n_state = S_RD;
                    end
                end else begin
                    if (cur[1] && r_lvl < LVL_W'(MAX_LVL)) begin
                        n_lvl   = r_lvl + LVL_W'(1);
                        n_pos   = POS_W'({r_pos, at_bit});
                        n_state = S_RD;
                    end else if (cur[0] && cur_off == r_at) begin
                        n_res_off = r_at;
                        n_res_lvl = r_lvl;
                        n_state   = S_FRW;
                    end else begin
                        n_res_st = ST_NOBLOCK;
                        n_state  = S_FIN;
                    end
                end
            end
            S_SPL: begin
                mem_we = (r_lvl != '0);
                mem_wd = FLAGS_SPLIT;
                if (r_lvl == '0) begin
                    n_root = FLAGS_SPLIT;
                end
                n_state = S_SPR;
            end
            S_SPR: begin
                // The right child starts free; the left one is written next.
                mem_we   = 1'b1;
                mem_addr = node_idx(r_lvl + LVL_W'(1), POS_W'({r_pos, 1'b1}));
                mem_wd   = FLAGS_FREE;
                n_lvl    = r_lvl + LVL_W'(1);
                n_pos    = POS_W'({r_pos, 1'b0});
                n_state  = ((r_lvl + LVL_W'(1)) < r_need.lvl) ? S_SPL : S_ALC;
            end
            S_ALC: begin
                mem_we = (r_lvl != '0);
                mem_wd = FLAGS_ALLOC;
                if (r_lvl == '0) begin
                    n_root = FLAGS_ALLOC;
                end
                n_res_lvl = r_lvl;
                n_res_st  = ST_OK;
                n_state   = S_FIN;
            end
            S_FRW: begin
                mem_we = (r_lvl != '0);
                mem_wd = FLAGS_FREE;
                if (r_lvl == '0) begin
                    n_root   = FLAGS_FREE;
                    n_res_st = ST_OK;
                    n_state  = S_FIN;
                end else begin
                    n_state = S_MRD;
                end
            end
            S_MRD: begin
                mem_addr = node_idx(r_lvl, r_pos ^ POS_W'(1));
                n_state  = S_MEV;
            end
            S_MEV: begin
                if (r_rdata != FLAGS_FREE) begin
                    n_res_st = ST_OK;
                    n_state  = S_FIN;
                end else begin
                    n_lvl   = r_lvl - LVL_W'(1);
                    n_pos   = r_pos >> 1;
                    n_state = S_FRW;
                end
            end
            S_FIN: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wd;
        end
        r_rdata <= mem[mem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_root    <= FLAGS_FREE;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_root  <= n_root;
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_kind <= i_req.kind;
            r_at   <= i_req.block_offset;
            r_need <= dec_need;
        end
        r_lvl     <= n_lvl;
        r_pos     <= n_pos;
        r_res_lvl <= n_res_lvl;
        r_res_off <= n_res_off;
        r_res_st  <= n_res_st;
        if (out_load) begin
            r_o_status <= r_res_st;
            if (r_res_st == ST_OK) begin
                r_o_off  <= r_res_off;
                r_o_size <= SIZE_W'(TOTAL_SIZE) >> r_res_lvl;
            end else begin
                r_o_off  <= '0;
                r_o_size <= '0;
            end
        end
    end

    assign o_rsp.valid          = r_o_valid;
    assign o_rsp.status         = r_o_status;
    assign o_rsp.granted_offset = r_o_off;
    assign o_rsp.granted_size   = r_o_size;

`ifndef ASSERT_OFF
    a_root_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_root != 2'b11)
        else $error("root is both split and allocated");
    a_lvl_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> r_lvl <= LVL_W'(MAX_LVL))
        else $error("walk level beyond the leaf level");
    a_ok_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.status == ST_OK |-> o_rsp.granted_size >= SIZE_W'(MIN_BLOCK))
        else $error("granted block below the minimum size");
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.status != ST_OK |->
            o_rsp.granted_size == '0 && o_rsp.granted_offset == '0)
        else $error("failed response carries a block");
`endif
endmodule
`default_nettype wire

FILE: tb/buddy_block_allocator_tb.sv
// Testbench for the buddy block allocator: directed and random allocate/free
// words checked against a flag-tree predictor. Depends on bba_pkg and bba_if.
`timescale 1ns / 1ps
module buddy_block_allocator_tb;
    import bba_pkg::*;

    typedef struct packed {
        logic             kind;
        logic [REQ_W-1:0] request_size;
        logic [OFF_W-1:0] block_offset;
    } t_req_word;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [OFF_W-1:0]  offset;
        logic [SIZE_W-1:0] size;
    } t_grant;

    localparam int WATCHDOG_LIMIT = 30000;
    localparam int RANDOM_ITEMS   = 1300;

    logic i_clk;
    logic i_rst_n;

    bba_req_if req_if ();
    bba_rsp_if rsp_if ();

    buddy_block_allocator u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    t_req_word pending_words[$];
    t_grant    grants_due[$];
    int        live_offsets[$];
    t_flags    tree[NODE_COUNT];

    int  mismatches   = 0;
    int  words_sent   = 0;
    int  grants_seen  = 0;
    int  allocs_ok    = 0;
    int  frees_ok     = 0;
    int  alloc_fails  = 0;
    int  free_fails   = 0;
    int  hold_cycles  = 0;
    int  hold_request = 0;
    bit  no_idle      = 1'b0;
    bit  req_taken    = 1'b0;
    int  quiet_cycles = 0;

    // Preorder, lower-half-first search for a free leaf of at least need units.
    function automatic int find_free_leaf(int idx, int span, int need);
        int hit;
        if (idx >= NODE_COUNT) return -1;
        if (tree[idx][0] || span < need) return -1;
        if (!tree[idx][1]) return idx;
        if (span == need) return -1;
        hit = find_free_leaf(2 * idx + 1, span / 2, need);
        if (hit >= 0) return hit;
        return find_free_leaf(2 * idx + 2, span / 2, need);
    endfunction

    task automatic predict_grant(input t_req_word w);
        t_grant g;
        int need, idx, span, off, depth, at, p, k;
        g = '0;
        if (w.kind == KIND_ALLOC) begin
            need = MIN_BLOCK;
            while (need < int'(w.request_size) && need <= TOTAL_SIZE) need <<= 1;
            idx = (need > TOTAL_SIZE) ? -1 : find_free_leaf(0, TOTAL_SIZE, need);
            if (idx < 0) begin
                g.status = ST_NOSPACE;
                alloc_fails++;
            end else begin
                depth = 0;
                while (((1 << (depth + 1)) - 1) <= idx) depth++;
                span = TOTAL_SIZE >> depth;
                off = (idx - ((1 << depth) - 1)) * span;
                while (span > need && span > MIN_BLOCK && 2 * idx + 2 < NODE_COUNT) begin
                    tree[idx] = FLAGS_SPLIT;
                    tree[2 * idx + 1] = FLAGS_FREE;
                    tree[2 * idx + 2] = FLAGS_FREE;
                    idx = 2 * idx + 1;
                    span /= 2;
                end
                tree[idx] = FLAGS_ALLOC;
                g.status = ST_OK;
                g.offset = OFF_W'(off);
                g.size = SIZE_W'(span);
                live_offsets.push_back(off);
                allocs_ok++;
            end
        end else begin
            at = int'(w.block_offset);
            idx = 0;
            off = 0;
            span = TOTAL_SIZE;
            while (tree[idx][1] && 2 * idx + 2 < NODE_COUNT) begin
                span /= 2;
                if (at >= off + span) begin
                    idx = 2 * idx + 2;
                    off += span;
                end else begin
                    idx = 2 * idx + 1;
                end
            end
            if (at >= TOTAL_SIZE || !tree[idx][0] || off != at) begin
                g.status = ST_NOBLOCK;
                free_fails++;
            end else begin
                tree[idx] = FLAGS_FREE;
                while (idx > 0) begin
                    p = (idx - 1) / 2;
                    if (tree[2 * p + 1] != FLAGS_FREE || tree[2 * p + 2] != FLAGS_FREE) break;
                    tree[p] = FLAGS_FREE;
                    idx = p;
                end
                g.status = ST_OK;
                g.offset = OFF_W'(off);
                g.size = SIZE_W'(span);
                for (k = 0; k < live_offsets.size(); k++) begin
                    if (live_offsets[k] == off) begin
                        live_offsets.delete(k);
                        break;
                    end
                end
                frees_ok++;
            end
        end
        grants_due.push_back(g);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("MISMATCH grant %0d %s: got %0d expected %0d", grants_seen, what, got, want);
    endtask

    // Request driver: acceptance is seen at the rising edge, new words go out
    // at the falling edge.
    always @(posedge i_clk) begin
        if (i_rst_n && req_if.valid && req_if.ready) begin
            predict_grant(pending_words.pop_front());
            words_sent++;
            req_taken <= 1'b1;
        end else begin
            req_taken <= 1'b0;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || req_taken) begin
            if (pending_words.size() > 0 && (no_idle || $urandom_range(99) >= 6)) begin
                req_if.valid <= 1'b1;
                req_if.kind <= pending_words[0].kind;
                req_if.request_size <= pending_words[0].request_size;
                req_if.block_offset <= pending_words[0].block_offset;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // Response side: random stalls plus one long hold-off on request.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else if (hold_request > 0 && hold_cycles == 0) begin
            hold_cycles <= hold_request;
            hold_request <= 0;
            rsp_if.ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= no_idle || ($urandom_range(99) >= 6);
        end
    end

    always @(posedge i_clk) begin
        t_grant want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            grants_seen++;
            if (grants_due.size() == 0) begin
                report_mismatch("unexpected word, grants pending", 0, 1);
            end else begin
                want = grants_due.pop_front();
                if (rsp_if.status !== want.status)
                    report_mismatch("status", rsp_if.status, want.status);
                if (rsp_if.granted_offset !== want.offset)
                    report_mismatch("offset", rsp_if.granted_offset, want.offset);
                if (rsp_if.granted_size !== want.size)
                    report_mismatch("size", rsp_if.granted_size, want.size);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog expired with %0d grants outstanding", grants_due.size());
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic queue_word(input logic kind, input int req, input int at);
        t_req_word w;
        w.kind = kind;
        w.request_size = REQ_W'(req);
        w.block_offset = OFF_W'(at);
        while (pending_words.size() >= 2) @(posedge i_clk);
        pending_words.push_back(w);
    endtask

    task automatic drain_grants();
        while (pending_words.size() > 0 || grants_due.size() > 0) @(posedge i_clk);
    endtask

    task automatic queue_random_word();
        int r, pick;
        r = $urandom_range(99);
        if (live_offsets.size() > 0 && r < ((live_offsets.size() > 60) ? 70 : 42)) begin
            pick = live_offsets[$urandom_range(live_offsets.size() - 1)];
            r = $urandom_range(99);
            if (r < 85) queue_word(KIND_FREE, $urandom_range(4095), pick);
            else queue_word(KIND_FREE, $urandom_range(4095), (pick + $urandom_range(1, 7)) % 2048);
        end else if (r >= 90) begin
            queue_word(KIND_FREE, $urandom_range(4095), $urandom_range(2047));
        end else begin
            r = $urandom_range(99);
            if (r < 55) queue_word(KIND_ALLOC, $urandom_range(40), $urandom_range(2047));
            else if (r < 85) queue_word(KIND_ALLOC, $urandom_range(300), $urandom_range(2047));
            else if (r < 95) queue_word(KIND_ALLOC, $urandom_range(2048), $urandom_range(2047));
            else queue_word(KIND_ALLOC, $urandom_range(2049, 4095), $urandom_range(2047));
        end
    endtask

    initial begin
        int n;
        for (n = 0; n < NODE_COUNT; n++) tree[n] = FLAGS_FREE;
        req_if.valid = 1'b0;
        req_if.kind = KIND_ALLOC;
        req_if.request_size = '0;
        req_if.block_offset = '0;
        rsp_if.ready = 1'b0;
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Zero size, minimum sizes, rounding, oversized and no-fit requests,
        // then bad frees (inside a block, on a free leaf, at the top offset) and valid frees.
        queue_word(KIND_ALLOC, 0, 0);
        queue_word(KIND_ALLOC, 1, 0);
        queue_word(KIND_ALLOC, 8, 0);
        queue_word(KIND_ALLOC, 9, 0);
        queue_word(KIND_ALLOC, 2048, 0);
        queue_word(KIND_ALLOC, 4095, 2047);
        queue_word(KIND_ALLOC, 1024, 0);
        queue_word(KIND_ALLOC, 1024, 0);
        queue_word(KIND_FREE, 0, 4);
        queue_word(KIND_FREE, 0, 48);
        queue_word(KIND_FREE, 0, 2047);
        queue_word(KIND_FREE, 4095, 8);
        queue_word(KIND_FREE, 0, 0);
        queue_word(KIND_FREE, 0, 16);
        queue_word(KIND_FREE, 0, 32);
        queue_word(KIND_FREE, 0, 1024);
        queue_word(KIND_FREE, 0, 1024);
        queue_word(KIND_ALLOC, 2048, 0);
        queue_word(KIND_ALLOC, 1, 0);
        queue_word(KIND_FREE, 0, 0);
        queue_word(KIND_ALLOC, 2047, 0);
        queue_word(KIND_FREE, 0, 0);
        queue_word(KIND_ALLOC, 2049, 0);
        drain_grants();

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 200) hold_request = 400;
            no_idle = (n >= 400 && n < 600);
            if (n == 700) drain_grants();
            queue_random_word();
        end
        no_idle = 1'b0;
        drain_grants();
        repeat (100) @(posedge i_clk);

        $display("Covered %0d words: %0d allocations, %0d frees, %0d no-space, %0d bad frees.",
                 words_sent, allocs_ok, frees_ok, alloc_fails, free_fails);
        $display("Checked %0d grant words, %0d mismatches.", grants_seen, mismatches);
        if (mismatches == 0 && grants_due.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
